// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// shared constants, codes and control types of the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W    = 5;
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int RES_W      = 32;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [RES_W-1:0]      res_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE   = 1'b0,
    S_FINISH = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load_result;
  } deq_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic out_stall;
  } deq_stat_t;

endpackage

// ===== rtl/deq_req_if.sv =====
// ----------------------------------------------------------------------------
// deq_req_if
// request channel: command and data word
// ----------------------------------------------------------------------------
interface deq_req_if;
  import deq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [DATA_WIDTH-1:0]  value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

// ===== rtl/deq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// deq_rsp_if
// response channel: result word, status and entry count
// ----------------------------------------------------------------------------
interface deq_rsp_if;
  import deq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [RES_W-1:0]     value_res;
  logic [STATUS_W-1:0]  status;
  logic [COUNT_W-1:0]   count;

  modport source (output valid, output value_res, output status, output count, input ready);
  modport sink   (input valid, input value_res, input status, input count, output ready);
endinterface

// ===== rtl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// sequencer: takes an item, then hands its result to the output register
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  deq_pkg::deq_stat_t stat,
  output deq_pkg::deq_ctrl_t ctrl
);
  import deq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    ctrl.accept      = 1'b0;
    ctrl.load_result = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        ctrl.accept = in_valid;
      end
      S_FINISH: begin
        ctrl.load_result = !stat.out_stall;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/deq_dpath.sv =====
// ----------------------------------------------------------------------------
// deq_dpath
// circular store, front index, entry count and result register
// ----------------------------------------------------------------------------
module deq_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  deq_pkg::deq_ctrl_t            ctrl,
  output deq_pkg::deq_stat_t            stat,
  input  logic [deq_pkg::CMD_W-1:0]     command,
  input  logic [deq_pkg::DATA_WIDTH-1:0] value,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [deq_pkg::RES_W-1:0]     value_res,
  output logic [deq_pkg::STATUS_W-1:0]  status,
  output logic [deq_pkg::COUNT_W-1:0]   count
);
  import deq_pkg::*;

  localparam int SUM_W = IDX_W + 1;

  data_t   mem [DEPTH];
  data_t   rd_data;
  idx_t    front;
  count_t  entry_count;
  status_t p_status;
  count_t  p_count;
  logic    p_use_data;

  logic    full;
  logic    empty;
  idx_t    front_dec;
  idx_t    front_inc;
  idx_t    tail_slot;
  idx_t    last_slot;
  idx_t    wr_addr;
  idx_t    rd_addr;
  logic    wr_en;
  idx_t    front_next;
  count_t  entry_count_next;
  status_t status_now;
  logic    use_data_now;

  function automatic idx_t slot_after(input idx_t base, input idx_t offset);
    logic [SUM_W-1:0] s;
    s = {1'b0, base} + {1'b0, offset};
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  assign full  = (entry_count == COUNT_W'(DEPTH));
  assign empty = (entry_count == '0);

  assign front_dec = (front == '0) ? IDX_W'(DEPTH - 1) : (front - idx_t'(1));
  assign front_inc = slot_after(front, idx_t'(1));
  assign tail_slot = slot_after(front, entry_count[IDX_W-1:0]);
  assign last_slot = slot_after(front, entry_count[IDX_W-1:0] - idx_t'(1));

  always_comb begin
    wr_en            = 1'b0;
    wr_addr          = tail_slot;
    rd_addr          = front;
    front_next       = front;
    entry_count_next = entry_count;
    status_now       = ST_OK;
    use_data_now     = 1'b0;
    case (command)
      CMD_PUSH_FRONT: begin
        wr_addr = front_dec;
        if (full) begin
          status_now = ST_FULL;
        end else begin
          wr_en            = 1'b1;
          front_next       = front_dec;
          entry_count_next = entry_count + count_t'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status_now = ST_FULL;
        end else begin
          wr_en            = 1'b1;
          entry_count_next = entry_count + count_t'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_now = ST_EMPTY;
        end else begin
          use_data_now     = 1'b1;
          front_next       = front_inc;
          entry_count_next = entry_count - count_t'(1);
        end
      end
      CMD_POP_BACK: begin
        rd_addr = last_slot;
        if (empty) begin
          status_now = ST_EMPTY;
        end else begin
          use_data_now     = 1'b1;
          entry_count_next = entry_count - count_t'(1);
        end
      end
      CMD_PEEK_FRONT: begin
        if (empty) begin
          status_now = ST_EMPTY;
        end else begin
          use_data_now = 1'b1;
        end
      end
      CMD_PEEK_BACK: begin
        rd_addr = last_slot;
        if (empty) begin
          status_now = ST_EMPTY;
        end else begin
          use_data_now = 1'b1;
        end
      end
      default: begin
        status_now = ST_OK;
      end
    endcase
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.accept && wr_en) begin
      mem[wr_addr] <= value;
    end
    if (ctrl.accept) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front       <= '0;
      entry_count <= '0;
    end else if (ctrl.accept) begin
      front       <= front_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      p_status   <= status_now;
      p_count    <= entry_count_next;
      p_use_data <= use_data_now;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_result) begin
      value_res <= p_use_data ? RES_W'(rd_data) : '0;
      status    <= p_status;
      count     <= p_count;
    end
  end

  assign stat.out_stall = out_valid && !out_ready;

endmodule

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded double-ended queue of data words in a circular store
//
//   channel    role   fields
//   request    sink   command, value
//   response   source value_res, status, count
//
// each item is taken in S_IDLE, which updates the indexes and reads the store into
// its read register, and finished in S_FINISH, which loads that read into the result register
// the next item is taken while a result still waits in the result register
// a stalled response holds the sequencer in S_FINISH
// reset (rst, synchronous) empties the queue; store contents are not cleared
// ----------------------------------------------------------------------------
module double_ended_queue (
  input logic          clk,
  input logic          rst,
  deq_req_if.sink      request,
  deq_rsp_if.source    response
);
  import deq_pkg::*;

  deq_ctrl_t ctrl;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  deq_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .command   (request.command),
    .value     (request.value),
    .out_ready (response.ready),
    .out_valid (response.valid),
    .value_res (response.value_res),
    .status    (response.status),
    .count     (response.count)
  );

endmodule
